[hw/rtl/tpft_pkg.sv]
`default_nettype none
package tpft_pkg;

  localparam int MaxPoints   = 16;
  localparam int RingEntries = 17;
  localparam int IdxW        = $clog2(MaxPoints);
  localparam int CntW        = $clog2(MaxPoints + 1);
  localparam int SlotW       = 5;

  localparam logic [1:0] ACT_POINT = 2'd0;
  localparam logic [1:0] ACT_EMPTY = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;
  localparam logic [1:0] ACT_UNDEF = 2'd3;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [1:0] TIMEOUT_START = 2'd3;

  typedef struct packed {
    logic [14:0]       id;
    logic [14:0]       x;
    logic [14:0]       y;
    logic [14:0]       minor;
    logic [14:0]       major;
    logic signed [7:0] angle;
    logic [1:0]        attr;
  } point_t;

  typedef struct packed {
    point_t     pt;
    logic [1:0] timeout;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CP_RD,
    S_CP_WR,
    S_HD_RD,
    S_HD_CMP,
    S_HD_WR,
    S_AG_RD,
    S_AG_WR,
    S_EM_RD,
    S_EM_LD,
    S_EM_WAIT
  } state_t;

endpackage
`default_nettype wire

[hw/rtl/touch_point_frame_table_top.sv]
`default_nettype none
// Touch point table. One request is taken at a time; s_tready is high only when the block is
// idle. The point that closes a frame (or an empty frame) then merges the frame: staged points
// first, then old table points. An update tick ages and compacts the table, then emits its
// results, waiting on any output stall. All work runs through one point memory (two banks, one
// read and one write port) and one staging memory.
module touch_point_frame_table_top (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // host_id, host_x, host_y, host_minor, host_major, host_angle, host_attribute, zero pad
  input  wire logic [103:0] s_tdata,
  // action
  input  wire logic [1:0]   s_tuser,
  input  wire logic         s_tlast,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // sampling_number, ring_slot, ring_fill, touch_count, out_id, out_x, out_y,
  // out_minor, out_major, out_angle, out_attribute, zero pad
  output logic [135:0]      m_tdata,
  output logic              m_tlast,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  tpft_pkg::state_t state, state_next;

  logic [14:0] screen_width, screen_height;

  tpft_pkg::entry_t pmem [2*tpft_pkg::MaxPoints];
  tpft_pkg::point_t smem [tpft_pkg::MaxPoints];
  tpft_pkg::entry_t pmem_rd;
  tpft_pkg::point_t smem_rd;

  logic                      bank;
  logic [tpft_pkg::CntW-1:0] point_count, staged_count;
  logic [tpft_pkg::CntW-1:0] rd_idx, wr_idx;
  logic [31:0]               sample_counter;
  logic [tpft_pkg::SlotW-1:0] current_slot, fill_level;
  logic [14:0]               ids [tpft_pkg::MaxPoints];
  logic [tpft_pkg::MaxPoints-1:0] match;
  tpft_pkg::entry_t          hold;

  logic in_acc, out_acc;
  logic pm_we, sm_we;
  logic [tpft_pkg::IdxW:0]   pm_waddr, pm_raddr;
  tpft_pkg::entry_t          pm_wdata;
  tpft_pkg::point_t          staged_pt;
  logic                      keep, held_ok;
  logic [tpft_pkg::CntW-1:0] emit_n;

  assign pready   = 1'b1;
  assign s_tready = (state == tpft_pkg::S_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign out_acc  = m_tvalid && m_tready;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= 15'd1;
      screen_height <= 15'd1;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == tpft_pkg::REG_WIDTH) screen_width <= pwdata[14:0];
      else screen_height <= pwdata[14:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == tpft_pkg::REG_WIDTH) prdata = {17'd0, screen_width};
    else prdata = {17'd0, screen_height};
  end

  // point clamp
  always_comb begin
    logic [14:0]        w, h;
    logic signed [16:0] v, wm1, hm1, wf;
    w   = (screen_width == 15'd0) ? 15'd1 : screen_width;
    h   = (screen_height == 15'd0) ? 15'd1 : screen_height;
    wf  = signed'({2'b00, w});
    wm1 = wf - 17'sd1;
    hm1 = signed'({2'b00, h}) - 17'sd1;
    staged_pt.attr = s_tdata[97:96];
    v = 17'(signed'(s_tdata[15:0]));
    staged_pt.id = (v < 17'sd0) ? 15'd0 : v[14:0];
    v = 17'(signed'(s_tdata[31:16]));
    staged_pt.x = (v < 17'sd0) ? 15'd0 : ((v > wm1) ? wm1[14:0] : v[14:0]);
    v = 17'(signed'(s_tdata[47:32]));
    staged_pt.y = (v < 17'sd0) ? 15'd0 : ((v > hm1) ? hm1[14:0] : v[14:0]);
    v = 17'(signed'(s_tdata[63:48]));
    staged_pt.minor = (v < 17'sd0) ? 15'd0 : ((v > wf) ? wf[14:0] : v[14:0]);
    v = 17'(signed'(s_tdata[79:64]));
    staged_pt.major = (v < 17'sd0) ? 15'd0 : ((v > wf) ? wf[14:0] : v[14:0]);
    v = 17'(signed'(s_tdata[95:80]));
    staged_pt.angle = (v < -17'sd90) ? -8'sd90 : ((v > 17'sd90) ? 8'sd90 : v[7:0]);
  end

  assign sm_we = in_acc && (s_tuser == tpft_pkg::ACT_POINT)
                 && (staged_count < 5'(tpft_pkg::MaxPoints));

  assign keep    = !pmem_rd.pt.attr[1] || (pmem_rd.timeout != 2'd0);
  assign held_ok = hold.pt.attr[1] && (hold.timeout != 2'd0) && (match == '0);
  assign emit_n  = (point_count == '0) ? 5'd1 : point_count;

  // memory access control
  always_comb begin
    pm_we    = 1'b0;
    pm_waddr = {~bank, wr_idx[tpft_pkg::IdxW-1:0]};
    pm_wdata = '{pt: smem_rd,
                 timeout: smem_rd.attr[1] ? tpft_pkg::TIMEOUT_START : 2'd0};
    pm_raddr = {bank, rd_idx[tpft_pkg::IdxW-1:0]};
    unique case (state)
      tpft_pkg::S_CP_WR: pm_we = 1'b1;
      tpft_pkg::S_HD_WR: begin
        pm_we    = held_ok;
        pm_wdata = hold;
      end
      tpft_pkg::S_AG_WR: begin
        pm_we    = keep;
        pm_waddr = {bank, wr_idx[tpft_pkg::IdxW-1:0]};
        pm_wdata = pmem_rd;
        if (pmem_rd.pt.attr[1]) pm_wdata.timeout = pmem_rd.timeout - 2'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pm_we) pmem[pm_waddr] <= pm_wdata;
    pmem_rd <= pmem[pm_raddr];
  end

  always_ff @(posedge clk) begin
    if (sm_we) smem[staged_count[tpft_pkg::IdxW-1:0]] <= staged_pt;
    smem_rd <= smem[rd_idx[tpft_pkg::IdxW-1:0]];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= tpft_pkg::S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tpft_pkg::S_IDLE: begin
        if (in_acc) begin
          priority if ((s_tuser == tpft_pkg::ACT_POINT && s_tlast)
                       || s_tuser == tpft_pkg::ACT_EMPTY) state_next = tpft_pkg::S_CP_RD;
          else if (s_tuser == tpft_pkg::ACT_TICK) state_next = tpft_pkg::S_AG_RD;
          else state_next = tpft_pkg::S_IDLE;
        end
      end
      tpft_pkg::S_CP_RD:
        state_next = (rd_idx < staged_count) ? tpft_pkg::S_CP_WR : tpft_pkg::S_HD_RD;
      tpft_pkg::S_CP_WR: state_next = tpft_pkg::S_CP_RD;
      tpft_pkg::S_HD_RD:
        state_next = (rd_idx < point_count && wr_idx < 5'(tpft_pkg::MaxPoints))
                     ? tpft_pkg::S_HD_CMP : tpft_pkg::S_IDLE;
      tpft_pkg::S_HD_CMP: state_next = tpft_pkg::S_HD_WR;
      tpft_pkg::S_HD_WR:  state_next = tpft_pkg::S_HD_RD;
      tpft_pkg::S_AG_RD:
        state_next = (rd_idx < point_count) ? tpft_pkg::S_AG_WR : tpft_pkg::S_EM_RD;
      tpft_pkg::S_AG_WR: state_next = tpft_pkg::S_AG_RD;
      tpft_pkg::S_EM_RD: state_next = tpft_pkg::S_EM_LD;
      tpft_pkg::S_EM_LD: state_next = tpft_pkg::S_EM_WAIT;
      tpft_pkg::S_EM_WAIT: begin
        if (out_acc) state_next = (rd_idx + 5'd1 >= emit_n) ? tpft_pkg::S_IDLE
                                                            : tpft_pkg::S_EM_RD;
      end
      default: state_next = tpft_pkg::S_IDLE;
    endcase
  end

  // control and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      bank           <= 1'b0;
      point_count    <= '0;
      staged_count   <= '0;
      rd_idx         <= '0;
      wr_idx         <= '0;
      sample_counter <= '0;
      current_slot   <= '0;
      fill_level     <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      unique case (state)
        tpft_pkg::S_IDLE: begin
          rd_idx <= '0;
          wr_idx <= '0;
          if (in_acc) begin
            if (sm_we) staged_count <= staged_count + 5'd1;
            if (s_tuser == tpft_pkg::ACT_EMPTY) staged_count <= '0;
          end
        end
        tpft_pkg::S_CP_RD: if (rd_idx >= staged_count) rd_idx <= '0;
        tpft_pkg::S_CP_WR: begin
          rd_idx <= rd_idx + 5'd1;
          wr_idx <= wr_idx + 5'd1;
        end
        tpft_pkg::S_HD_RD: begin
          if (!(rd_idx < point_count && wr_idx < 5'(tpft_pkg::MaxPoints))) begin
            bank         <= ~bank;
            point_count  <= wr_idx;
            staged_count <= '0;
          end
        end
        tpft_pkg::S_HD_CMP: ;
        tpft_pkg::S_HD_WR: begin
          rd_idx <= rd_idx + 5'd1;
          if (held_ok) wr_idx <= wr_idx + 5'd1;
        end
        tpft_pkg::S_AG_RD: begin
          if (rd_idx >= point_count) begin
            point_count    <= wr_idx;
            rd_idx         <= '0;
            sample_counter <= sample_counter + 32'd1;
            current_slot   <= (current_slot == 5'(tpft_pkg::RingEntries - 1))
                              ? '0 : current_slot + 5'd1;
            if (fill_level < 5'(tpft_pkg::RingEntries - 1)) fill_level <= fill_level + 5'd1;
          end
        end
        tpft_pkg::S_AG_WR: begin
          rd_idx <= rd_idx + 5'd1;
          if (keep) wr_idx <= wr_idx + 5'd1;
        end
        tpft_pkg::S_EM_RD: ;
        tpft_pkg::S_EM_LD: m_tvalid <= 1'b1;
        tpft_pkg::S_EM_WAIT: begin
          if (out_acc) begin
            m_tvalid <= 1'b0;
            rd_idx   <= rd_idx + 5'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // id list of the table being built, and duplicate check
  always_ff @(posedge clk) begin
    if (state == tpft_pkg::S_CP_WR) ids[wr_idx[tpft_pkg::IdxW-1:0]] <= smem_rd.id;
    if (state == tpft_pkg::S_HD_WR && held_ok) ids[wr_idx[tpft_pkg::IdxW-1:0]] <= hold.pt.id;
    if (state == tpft_pkg::S_HD_CMP) begin
      hold <= pmem_rd;
      for (int e = 0; e < tpft_pkg::MaxPoints; e++) begin
        match[e] <= (5'(e) < wr_idx) && (ids[e] == pmem_rd.pt.id);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    tpft_pkg::point_t p;
    p = (point_count == '0) ? '0 : pmem_rd.pt;
    if (state == tpft_pkg::S_EM_LD) begin
      m_tdata <= {4'd0, p.attr, p.angle, p.major, p.minor, p.y, p.x, p.id,
                  point_count, fill_level, current_slot, sample_counter};
      m_tlast <= (rd_idx + 5'd1 >= emit_n);
    end
  end

endmodule
`default_nettype wire

[hw/rtl/tpft_checker.sv]
`default_nettype none
module tpft_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tvalid,
  input wire logic         s_tready,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [135:0] m_tdata,
  input wire logic         m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  a_no_req_while_result: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid)
    else $error("request taken while a result is pending");

  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> !s_tready)
    else $error("block went idle before the last result");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[46:42] <= 5'd16)
    else $error("touch count out of range");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind touch_point_frame_table_top tpft_checker u_tpft_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
`default_nettype wire
